>>> rtl/core/kbsm_pkg.sv
// shared types, constants and crc helper for the keyed block store manager
`default_nettype none
package kbsm_pkg;

  localparam int MAX_BLOCKS  = 32;
  localparam int BLOCK_BYTES = 256;
  localparam int SLOT_W      = $clog2(MAX_BLOCKS);
  localparam int BYTE_W      = $clog2(BLOCK_BYTES);
  localparam int ADDR_W      = SLOT_W + BYTE_W;
  localparam int CNT_W       = SLOT_W + 1;
  localparam int MEM_DEPTH   = MAX_BLOCKS * BLOCK_BYTES;
  localparam logic [31:0] MEM_TOTAL     = 32'(MEM_DEPTH);
  localparam logic [31:0] WEAR_RESET    = 32'd100000;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY      = 16'hA001;

  typedef enum logic [2:0] {
    ACT_WRITE   = 3'd0,
    ACT_READ    = 3'd1,
    ACT_STATUS  = 3'd2,
    ACT_INVAL   = 3'd3,
    ACT_ERASE   = 3'd4,
    ACT_PROTECT = 3'd5,
    ACT_STAT    = 3'd6,
    ACT_TICK    = 3'd7
  } act_e;

  typedef enum logic [2:0] {
    RC_OK        = 3'd0,
    RC_NOT_OK    = 3'd1,
    RC_UNKNOWN   = 3'd2,
    RC_PROTECTED = 3'd3,
    RC_FULL      = 3'd4,
    RC_INVALID   = 3'd5
  } rc_e;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_WRITING = 2'd1,
    ST_VALID   = 2'd2,
    ST_INVALID = 2'd3
  } blk_st_e;

  typedef enum logic [2:0] {
    CS_IDLE   = 3'd0,
    CS_SCAN   = 3'd1,
    CS_EXEC   = 3'd2,
    CS_RDWAIT = 3'd3,
    CS_OUT    = 3'd4
  } ctrl_st_e;

  typedef enum logic [2:0] {
    SEL_READS   = 3'd0,
    SEL_WRITES  = 3'd1,
    SEL_ERASES  = 3'd2,
    SEL_RDERR   = 3'd3,
    SEL_MEMUSED = 3'd4,
    SEL_MEMTOT  = 3'd5
  } sel_e;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic exec;
    logic rd_cap;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/kbsm_ctrl.sv
// sequencing state machine for the keyed block store manager
`default_nettype none
module kbsm_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  input  wire               out_stall_i,
  input  kbsm_pkg::sts_t    sts_i,
  output kbsm_pkg::cmd_t    cmd_o,
  output logic              in_stall_o,
  output logic              out_valid_o
);

  kbsm_pkg::ctrl_st_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kbsm_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      kbsm_pkg::CS_IDLE:   if (in_valid_i) state_d = kbsm_pkg::CS_SCAN;
      kbsm_pkg::CS_SCAN:   if (sts_i.scan_done) state_d = kbsm_pkg::CS_EXEC;
      kbsm_pkg::CS_EXEC:   state_d = kbsm_pkg::CS_RDWAIT;
      kbsm_pkg::CS_RDWAIT: state_d = kbsm_pkg::CS_OUT;
      kbsm_pkg::CS_OUT:    if (!out_stall_i) state_d = kbsm_pkg::CS_IDLE;
      default:             state_d = kbsm_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    in_stall_o      = 1'b1;
    out_valid_o     = 1'b0;
    case (state_q)
      kbsm_pkg::CS_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      kbsm_pkg::CS_SCAN:   cmd_o.scan_step = !sts_i.scan_done;
      kbsm_pkg::CS_EXEC:   cmd_o.exec = 1'b1;
      kbsm_pkg::CS_RDWAIT: cmd_o.rd_cap = 1'b1;
      kbsm_pkg::CS_OUT:    out_valid_o = 1'b1;
      default:             in_stall_o = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/kbsm_dp.sv
// tables, data memory, counters and result registers
`default_nettype none
module kbsm_dp (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  kbsm_pkg::cmd_t    cmd_i,
  output kbsm_pkg::sts_t    sts_o,
  input  wire               cfg_we_i,
  input  wire  [31:0]       cfg_data_i,
  input  wire  [2:0]        action_i,
  input  wire  [15:0]       block_id_i,
  input  wire  [7:0]        byte_index_i,
  input  wire  [7:0]        data_byte_i,
  input  wire               last_i,
  input  wire               protect_i,
  input  wire  [31:0]       now_time_i,
  input  wire  [2:0]        stat_select_i,
  output logic [2:0]        result_code_o,
  output logic [7:0]        read_data_o,
  output logic [1:0]        block_state_o,
  output logic [8:0]        data_length_o,
  output logic [15:0]       stored_crc_o,
  output logic [31:0]       write_count_o,
  output logic [31:0]       write_time_o,
  output logic              is_protected_o,
  output logic [31:0]       stat_value_o,
  output logic [5:0]        worn_blocks_o
);

  localparam int SW = kbsm_pkg::SLOT_W;
  localparam int CW = kbsm_pkg::CNT_W;

  // registered item
  logic [2:0]  act_q;
  logic [15:0] id_q;
  logic [7:0]  bidx_q, dbyte_q;
  logic        last_q, prot_q;
  logic [31:0] now_q;
  logic [2:0]  sel_q;

  logic [31:0] thr_q;

  // per-entry tables
  logic [15:0] id_tbl   [kbsm_pkg::MAX_BLOCKS];
  logic [1:0]  st_tbl   [kbsm_pkg::MAX_BLOCKS];
  logic        pr_tbl   [kbsm_pkg::MAX_BLOCKS];
  logic [8:0]  len_tbl  [kbsm_pkg::MAX_BLOCKS];
  logic [15:0] crc_tbl  [kbsm_pkg::MAX_BLOCKS];
  logic [31:0] wr_tbl   [kbsm_pkg::MAX_BLOCKS];
  logic [31:0] tm_tbl   [kbsm_pkg::MAX_BLOCKS];

  logic [7:0]  mem [kbsm_pkg::MEM_DEPTH];
  logic [7:0]  mem_rd_q;

  logic [CW-1:0] biu_q;
  logic [31:0]   cnt_q [4];
  logic [13:0]   mem_used_q;
  logic          open_q;
  logic [SW-1:0] oslot_q;
  logic [8:0]    nbyte_q;
  logic [15:0]   crc_q;

  // scan state
  logic [CW-1:0] ptr_q;
  logic          found_q;
  logic [SW-1:0] fslot_q;
  logic [CW-1:0] worn_q, used_q;

  logic          rd_ok_q;

  // table read port, one address
  logic [SW-1:0] s, taddr;
  logic [15:0] t_id;
  logic [1:0]  t_st;
  logic        t_pr;
  logic [8:0]  t_len;
  logic [15:0] t_crc;
  logic [31:0] t_wr, t_tm;

  assign s     = found_q ? fslot_q : biu_q[SW-1:0];
  assign taddr = cmd_i.exec ? s : ptr_q[SW-1:0];
  assign t_id  = id_tbl[taddr];
  assign t_st  = st_tbl[taddr];
  assign t_pr  = pr_tbl[taddr];
  assign t_len = len_tbl[taddr];
  assign t_crc = crc_tbl[taddr];
  assign t_wr  = wr_tbl[taddr];
  assign t_tm  = tm_tbl[taddr];

  logic in_range;
  assign in_range = ptr_q < biu_q;
  assign sts_o.scan_done = !in_range || found_q;

  // execute
  logic [2:0]  rc;
  logic        show, alloc, tbl_we, mem_we, rd_ok, cnt_inc;
  logic [1:0]  cnt_sel;
  logic [1:0]  n_st;
  logic        n_pr;
  logic [8:0]  n_len;
  logic [15:0] n_crc, crc_next;
  logic [31:0] n_wr, n_tm, stat;
  logic        n_open, start;
  logic [8:0]  idx9;
  logic        same_stream;

  assign idx9        = {1'b0, bidx_q};
  assign same_stream = open_q && (oslot_q == s);
  assign crc_next    = kbsm_pkg::crc_byte(start ? kbsm_pkg::CRC_INIT : crc_q, dbyte_q);

  always_comb begin
    rc = kbsm_pkg::RC_OK;
    show = 1'b0; alloc = 1'b0; tbl_we = 1'b0; mem_we = 1'b0; rd_ok = 1'b0;
    cnt_inc = 1'b0; cnt_sel = 2'd0; start = 1'b0;
    n_st = t_st; n_pr = t_pr; n_len = t_len; n_crc = t_crc; n_wr = t_wr; n_tm = t_tm;
    n_open = open_q;
    stat = '0;
    case (act_q)
      kbsm_pkg::ACT_STAT: begin
        case (sel_q)
          kbsm_pkg::SEL_READS:   stat = cnt_q[0];
          kbsm_pkg::SEL_WRITES:  stat = cnt_q[1];
          kbsm_pkg::SEL_ERASES:  stat = cnt_q[2];
          kbsm_pkg::SEL_RDERR:   stat = cnt_q[3];
          kbsm_pkg::SEL_MEMUSED: stat = {18'd0, mem_used_q};
          kbsm_pkg::SEL_MEMTOT:  stat = kbsm_pkg::MEM_TOTAL;
          default:               rc = kbsm_pkg::RC_NOT_OK;
        endcase
      end
      kbsm_pkg::ACT_TICK: rc = kbsm_pkg::RC_OK;
      kbsm_pkg::ACT_WRITE: begin
        if (!found_q && bidx_q != 8'd0) begin
          rc = kbsm_pkg::RC_INVALID;
        end else if (!found_q && biu_q == CW'(kbsm_pkg::MAX_BLOCKS)) begin
          rc = kbsm_pkg::RC_FULL;
        end else begin
          show  = 1'b1;
          alloc = !found_q;
          if (t_pr) begin
            rc = kbsm_pkg::RC_PROTECTED;
          end else if (bidx_q == 8'd0) begin
            start = 1'b1;
          end else if (!(same_stream && idx9 == nbyte_q)) begin
            rc = kbsm_pkg::RC_INVALID;
          end
          if (rc == kbsm_pkg::RC_OK) begin
            mem_we = 1'b1;
            tbl_we = 1'b1;
            n_open = 1'b1;
            n_st   = kbsm_pkg::ST_WRITING;
            if (last_q) begin
              n_len  = idx9 + 9'd1;
              n_crc  = crc_next;
              n_wr   = (t_wr != 32'hFFFF_FFFF) ? t_wr + 32'd1 : t_wr;
              n_tm   = now_q;
              n_st   = kbsm_pkg::ST_VALID;
              n_open = 1'b0;
              cnt_inc = 1'b1; cnt_sel = 2'd1;
            end else if (!start) begin
              n_st = t_st;
            end
          end
        end
      end
      default: begin
        if (!found_q) begin
          rc = kbsm_pkg::RC_UNKNOWN;
        end else begin
          show = 1'b1;
          case (act_q)
            kbsm_pkg::ACT_READ: begin
              if (t_st != kbsm_pkg::ST_VALID) begin
                rc = kbsm_pkg::RC_NOT_OK; cnt_inc = 1'b1; cnt_sel = 2'd3;
              end else if (idx9 >= t_len) begin
                rc = kbsm_pkg::RC_INVALID;
              end else begin
                rd_ok = 1'b1; cnt_inc = 1'b1; cnt_sel = 2'd0;
              end
            end
            kbsm_pkg::ACT_INVAL: begin
              if (t_pr) rc = kbsm_pkg::RC_PROTECTED;
              else begin
                tbl_we = 1'b1; n_st = kbsm_pkg::ST_INVALID;
                if (same_stream) n_open = 1'b0;
              end
            end
            kbsm_pkg::ACT_ERASE: begin
              if (t_pr) rc = kbsm_pkg::RC_PROTECTED;
              else begin
                tbl_we = 1'b1; n_st = kbsm_pkg::ST_EMPTY; n_len = '0; n_crc = '0;
                cnt_inc = 1'b1; cnt_sel = 2'd2;
                if (same_stream) n_open = 1'b0;
              end
            end
            kbsm_pkg::ACT_PROTECT: begin
              tbl_we = 1'b1; n_pr = prot_q;
            end
            default: rc = kbsm_pkg::RC_OK;
          endcase
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= kbsm_pkg::WEAR_RESET;
      biu_q <= '0; mem_used_q <= '0; open_q <= 1'b0; oslot_q <= '0;
      nbyte_q <= '0; crc_q <= kbsm_pkg::CRC_INIT;
      ptr_q <= '0; found_q <= 1'b0; fslot_q <= '0; worn_q <= '0; used_q <= '0;
      rd_ok_q <= 1'b0;
      for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
      for (int i = 0; i < kbsm_pkg::MAX_BLOCKS; i++) begin
        id_tbl[i] <= '0; st_tbl[i] <= kbsm_pkg::ST_EMPTY; pr_tbl[i] <= 1'b0;
        len_tbl[i] <= '0; crc_tbl[i] <= '0; wr_tbl[i] <= '0; tm_tbl[i] <= '0;
      end
    end else begin
      if (cfg_we_i) thr_q <= cfg_data_i;
      if (cmd_i.load) begin
        ptr_q <= '0; found_q <= 1'b0; worn_q <= '0; used_q <= '0;
      end
      if (cmd_i.scan_step) begin
        ptr_q <= ptr_q + CW'(1);
        if (act_q == kbsm_pkg::ACT_TICK) begin
          if (t_st != kbsm_pkg::ST_EMPTY) used_q <= used_q + CW'(1);
          if (t_wr > thr_q) worn_q <= worn_q + CW'(1);
        end else if (t_id == id_q) begin
          found_q <= 1'b1;
          fslot_q <= ptr_q[SW-1:0];
        end
      end
      if (cmd_i.exec) begin
        rd_ok_q <= rd_ok;
        if (act_q == kbsm_pkg::ACT_TICK) begin
          mem_used_q <= 14'({used_q, {kbsm_pkg::BYTE_W{1'b0}}});
        end
        if (alloc) begin
          id_tbl[s] <= id_q;
          biu_q <= biu_q + CW'(1);
        end
        if (tbl_we) begin
          st_tbl[s] <= n_st; pr_tbl[s] <= n_pr; len_tbl[s] <= n_len;
          crc_tbl[s] <= n_crc; wr_tbl[s] <= n_wr; tm_tbl[s] <= n_tm;
        end
        open_q <= n_open;
        if (mem_we) begin
          oslot_q <= s;
          nbyte_q <= idx9 + 9'd1;
          crc_q   <= crc_next;
        end
        if (cnt_inc) cnt_q[cnt_sel] <= cnt_q[cnt_sel] + 32'd1;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i; id_q <= block_id_i; bidx_q <= byte_index_i;
      dbyte_q <= data_byte_i; last_q <= last_i; prot_q <= protect_i;
      now_q <= now_time_i; sel_q <= stat_select_i;
    end
    if (cmd_i.exec) begin
      result_code_o  <= rc;
      block_state_o  <= show ? n_st  : 2'd0;
      data_length_o  <= show ? n_len : 9'd0;
      stored_crc_o   <= show ? n_crc : 16'd0;
      write_count_o  <= show ? n_wr  : 32'd0;
      write_time_o   <= show ? n_tm  : 32'd0;
      is_protected_o <= show ? n_pr  : 1'b0;
      stat_value_o   <= stat;
      worn_blocks_o  <= (act_q == kbsm_pkg::ACT_TICK) ? 6'(worn_q) : 6'd0;
    end
    if (cmd_i.rd_cap) read_data_o <= rd_ok_q ? mem_rd_q : 8'd0;
  end

  // data memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && mem_we) mem[{s, bidx_q}] <= dbyte_q;
    mem_rd_q <= mem[{s, bidx_q}];
  end

endmodule
`default_nettype wire

>>> rtl/core/keyed_block_store_manager_unit.sv
// top level of the keyed block store manager
//
//  channel | direction | handshake              | payload
//  in      | into unit | in_valid_i / in_stall_o | action .. stat_select
//  out     | from unit | out_valid_o / out_stall_i | result_code .. worn_blocks
//  cfg     | into unit | cfg_valid_i / cfg_ready_o | cfg_data_i (wear_threshold)
//
// one transaction at a time: accept, id scan (one table entry per cycle up to the
// number of allocated entries), execute, data memory read, result
// a tick always walks all allocated entries; statistic passes through the scan too
// result valid in the out state after the execute and read-wait states; a new accept only once it is taken
// async active-low reset clears tables and counters; the data memory is not cleared
// out stall holds the result register and keeps the input stalled
`default_nettype none
module keyed_block_store_manager_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  action_i,
  input  wire  [15:0] block_id_i,
  input  wire  [7:0]  byte_index_i,
  input  wire  [7:0]  data_byte_i,
  input  wire         last_i,
  input  wire         protect_i,
  input  wire  [31:0] now_time_i,
  input  wire  [2:0]  stat_select_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [2:0]  result_code_o,
  output logic [7:0]  read_data_o,
  output logic [1:0]  block_state_o,
  output logic [8:0]  data_length_o,
  output logic [15:0] stored_crc_o,
  output logic [31:0] write_count_o,
  output logic [31:0] write_time_o,
  output logic        is_protected_o,
  output logic [31:0] stat_value_o,
  output logic [5:0]  worn_blocks_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [31:0] cfg_data_i
);

  kbsm_pkg::cmd_t cmd;
  kbsm_pkg::sts_t sts;

  // threshold writes must arrive only while idle; the unit itself does not enforce this, so always ready
  assign cfg_ready_o = 1'b1;

  kbsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  kbsm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .action_i       (action_i),
    .block_id_i     (block_id_i),
    .byte_index_i   (byte_index_i),
    .data_byte_i    (data_byte_i),
    .last_i         (last_i),
    .protect_i      (protect_i),
    .now_time_i     (now_time_i),
    .stat_select_i  (stat_select_i),
    .result_code_o  (result_code_o),
    .read_data_o    (read_data_o),
    .block_state_o  (block_state_o),
    .data_length_o  (data_length_o),
    .stored_crc_o   (stored_crc_o),
    .write_count_o  (write_count_o),
    .write_time_o   (write_time_o),
    .is_protected_o (is_protected_o),
    .stat_value_o   (stat_value_o),
    .worn_blocks_o  (worn_blocks_o)
  );

endmodule
`default_nettype wire

>>> rtl/core/kbsm_chk.sv
// port-level checker for the keyed block store manager and its bind
`default_nettype none
module kbsm_chk (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_stall_o,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [2:0]  result_code_o,
  input wire [7:0]  read_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction taken while busy");

  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  a_read_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && read_data_o != 8'd0 |-> result_code_o == kbsm_pkg::RC_OK)
    else $error("read data on failed transaction");

endmodule

bind keyed_block_store_manager_unit kbsm_chk u_kbsm_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .result_code_o (result_code_o),
  .read_data_o   (read_data_o)
);
`default_nettype wire
